FILE: design/ppmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak picker package
// Shared widths, limits and the event record passed from front to back.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int POS_W       = 21;
  localparam int MAX_SAMPLES = 1048576;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic {
    REG_MIN_VALUE    = 1'b0,
    REG_MIN_DISTANCE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                       has_peak;
    logic                       fin;
    logic [POS_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] height;
  } peak_event_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } queue_status_t;

endpackage
`default_nettype wire

FILE: design/ppmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak picker front end
// Keeps the two newest samples and the sample count, and classifies each
// accepted sample into a peak event and an end-of-series event.
// ----------------------------------------------------------------------------
module ppmd_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic signed [ppmd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                                final_sample,
  input  wire logic signed [ppmd_pkg::SAMPLE_W-1:0] min_value,
  output ppmd_pkg::peak_event_t                    event_out,
  output logic                                     push
);

  logic signed [ppmd_pkg::SAMPLE_W-1:0] older_sample;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] newer_sample;
  logic [ppmd_pkg::POS_W-1:0]           sample_index;
  logic                                 in_range;
  logic                                 peak_newer;
  logic                                 peak_last;

  always_comb begin
    in_range   = sample_index < ppmd_pkg::POS_W'(ppmd_pkg::MAX_SAMPLES);
    peak_newer = in_range && (sample_index >= ppmd_pkg::POS_W'(2)) &&
                 (newer_sample > min_value) && (newer_sample > older_sample) &&
                 (newer_sample > sample);
    peak_last  = in_range && final_sample && (sample_index >= ppmd_pkg::POS_W'(1)) &&
                 (sample > min_value) && (sample > newer_sample);
    event_out.has_peak = peak_newer || peak_last;
    event_out.fin      = final_sample;
    event_out.idx      = peak_newer ? sample_index - ppmd_pkg::POS_W'(1) : sample_index;
    event_out.height   = peak_newer ? newer_sample : sample;
    push = accept && (peak_newer || peak_last || final_sample);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newer_sample <= '0;
      sample_index <= '0;
    end else if (accept) begin
      if (final_sample) begin
        older_sample <= '0;
        newer_sample <= '0;
        sample_index <= '0;
      end else if (in_range) begin
        older_sample <= newer_sample;
        newer_sample <= sample;
        sample_index <= sample_index + ppmd_pkg::POS_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/ppmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak picker event queue
// Short register FIFO that lets the front end and back end stall separately.
// ----------------------------------------------------------------------------
module ppmd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ppmd_pkg::peak_event_t push_data,
  input  wire logic                  pop,
  output ppmd_pkg::peak_event_t      head,
  output ppmd_pkg::queue_status_t    status
);

  ppmd_pkg::peak_event_t           entries [ppmd_pkg::QDEPTH];
  logic [ppmd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ppmd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ppmd_pkg::QCNT_W-1:0]     count;

  always_comb begin
    status.not_full  = count != ppmd_pkg::QCNT_W'(ppmd_pkg::QDEPTH);
    status.not_empty = count != '0;
    head             = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ppmd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ppmd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ppmd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ppmd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/ppmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak picker back end
// Holds the pending peak, applies the minimum distance rule, flushes at the
// end of a series and drives the registered result channel.
// ----------------------------------------------------------------------------
module ppmd_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ppmd_pkg::peak_event_t  head,
  input  wire ppmd_pkg::queue_status_t status,
  input  wire logic [ppmd_pkg::POS_W-1:0] min_distance,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ppmd_pkg::POS_W-1:0]  peak_position,
  output logic                        peak_valid,
  output logic                        end_of_list
);

  logic                                 pending_valid;
  logic [ppmd_pkg::POS_W-1:0]           pending_index;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] pending_height;
  logic                                 eol_due;

  logic                                 pending_valid_next;
  logic [ppmd_pkg::POS_W-1:0]           pending_index_next;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] pending_height_next;
  logic                                 eol_due_next;
  logic                                 out_valid_next;
  logic [ppmd_pkg::POS_W-1:0]           peak_position_next;
  logic                                 peak_valid_next;
  logic                                 end_of_list_next;

  logic                                 load;
  logic                                 far;
  logic                                 emit;
  logic                                 take;
  logic                                 np_valid;
  logic [ppmd_pkg::POS_W-1:0]           np_index;

  always_comb begin
    load     = !out_valid || out_ready;
    pop      = load && !eol_due && status.not_empty;
    far      = (head.idx - pending_index) > min_distance;
    emit     = head.has_peak && pending_valid && far;
    take     = head.has_peak && (!pending_valid || far || (head.height > pending_height));
    np_valid = pending_valid || head.has_peak;
    np_index = take ? head.idx : pending_index;

    pending_valid_next  = pending_valid;
    pending_index_next  = pending_index;
    pending_height_next = pending_height;
    eol_due_next        = eol_due;
    out_valid_next      = out_valid;
    peak_position_next  = peak_position;
    peak_valid_next     = peak_valid;
    end_of_list_next    = end_of_list;

    if (load) begin
      out_valid_next = 1'b0;
    end

    if (load && eol_due) begin
      out_valid_next      = 1'b1;
      peak_position_next  = pending_valid ? pending_index + ppmd_pkg::POS_W'(1) : '0;
      peak_valid_next     = pending_valid;
      end_of_list_next    = 1'b1;
      eol_due_next        = 1'b0;
      pending_valid_next  = 1'b0;
      pending_index_next  = '0;
      pending_height_next = '0;
    end else if (pop) begin
      pending_valid_next  = np_valid;
      pending_index_next  = np_index;
      pending_height_next = take ? head.height : pending_height;
      if (emit) begin
        out_valid_next     = 1'b1;
        peak_position_next = pending_index + ppmd_pkg::POS_W'(1);
        peak_valid_next    = 1'b1;
        end_of_list_next   = 1'b0;
        eol_due_next       = head.fin;
      end else if (head.fin) begin
        out_valid_next      = 1'b1;
        peak_position_next  = np_valid ? np_index + ppmd_pkg::POS_W'(1) : '0;
        peak_valid_next     = np_valid;
        end_of_list_next    = 1'b1;
        pending_valid_next  = 1'b0;
        pending_index_next  = '0;
        pending_height_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_index  <= '0;
      pending_height <= '0;
      eol_due        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pending_valid  <= pending_valid_next;
      pending_index  <= pending_index_next;
      pending_height <= pending_height_next;
      eol_due        <= eol_due_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    peak_position <= peak_position_next;
    peak_valid    <= peak_valid_next;
    end_of_list   <= end_of_list_next;
  end

endmodule
`default_nettype wire

FILE: design/peak_picker_min_distance.sv
// A result passes through the event queue and the result register after the
// transfer of the sample that decides it. Samples are taken one per cycle
// while the event queue is not full; a final sample that also confirms a peak
// gives two results, the second sent once the first is taken.
// Reset (rst, synchronous): clears the sample history, pending peak, queue,
// result valid and both configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak picker with minimum distance
// Finds local maxima above a threshold in a sample stream, keeps the highest
// of peaks that lie close together, and reports 1-based peak positions.
// ----------------------------------------------------------------------------
module peak_picker_min_distance (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [ppmd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                                 final_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ppmd_pkg::POS_W-1:0]                peak_position,
  output logic                                      peak_valid,
  output logic                                      end_of_list,
  input  wire logic                                 cfg_write,
  input  wire logic                                 cfg_index,
  input  wire logic [ppmd_pkg::SAMPLE_W-1:0]        cfg_data
);

  logic signed [ppmd_pkg::SAMPLE_W-1:0] min_value;
  logic [ppmd_pkg::POS_W-1:0]           min_distance;
  ppmd_pkg::peak_event_t                front_event;
  ppmd_pkg::peak_event_t                queue_head;
  ppmd_pkg::queue_status_t              queue_status;
  logic                                 push;
  logic                                 pop;
  logic                                 accept;

  assign in_ready = queue_status.not_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value    <= '0;
      min_distance <= '0;
    end else if (cfg_write) begin
      unique case (ppmd_pkg::reg_index_t'(cfg_index))
        ppmd_pkg::REG_MIN_VALUE:    min_value    <= $signed(cfg_data);
        ppmd_pkg::REG_MIN_DISTANCE: min_distance <= cfg_data[ppmd_pkg::POS_W-1:0];
        default:                    min_value    <= min_value;
      endcase
    end
  end

  ppmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (sample),
    .final_sample (final_sample),
    .min_value    (min_value),
    .event_out    (front_event),
    .push         (push)
  );

  ppmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_event),
    .pop       (pop),
    .head      (queue_head),
    .status    (queue_status)
  );

  ppmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (queue_head),
    .status        (queue_status),
    .min_distance  (min_distance),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .peak_position (peak_position),
    .peak_valid    (peak_valid),
    .end_of_list   (end_of_list)
  );

`ifndef SYNTHESIS
  a_no_peak_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !peak_valid |-> peak_position == '0)
    else $error("Result without a peak carries a nonzero position.");

  a_peak_nonzero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && peak_valid |-> peak_position != '0)
    else $error("Confirmed peak carries position zero.");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> queue_status.not_empty)
    else $error("Back end took an event from an empty queue.");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid set right after reset.");
`endif

endmodule
`default_nettype wire

FILE: bench/peak_picker_min_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak picker with minimum distance: self-checking testbench
// Sends sample series through the valid/ready input and predicts each peak
// report in a behavioral copy of the picker. Reports are compared field by
// field in order. Coverage: directed edge cases, randomized series under
// changing thresholds and spacings, and a long receiver stall.
// ----------------------------------------------------------------------------
module peak_picker_min_distance_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 100;

  typedef struct packed {
    logic [ppmd_pkg::POS_W-1:0] position;
    logic                       found;
    logic                       closing;
  } peak_report_t;

  typedef enum logic [1:0] {STYLE_WIDE, STYLE_NARROW, STYLE_SAW, STYLE_WALK} series_style_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                                 clk          = 1'b0;
  logic                                 rst          = 1'b1;
  logic                                 in_valid     = 1'b0;
  logic                                 in_ready;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] sample       = '0;
  logic                                 final_sample = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready    = 1'b0;
  logic [ppmd_pkg::POS_W-1:0]           peak_position;
  logic                                 peak_valid;
  logic                                 end_of_list;
  logic                                 cfg_write    = 1'b0;
  logic                                 cfg_index    = 1'b0;
  logic [ppmd_pkg::SAMPLE_W-1:0]        cfg_data     = '0;

  // Behavioral copy of the picker.
  logic signed [ppmd_pkg::SAMPLE_W-1:0] threshold;
  logic [ppmd_pkg::POS_W-1:0]           spacing;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] hist_prev;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] hist_last;
  int unsigned                          seen_count;
  logic                                 held_valid;
  int unsigned                          held_index;
  logic signed [ppmd_pkg::SAMPLE_W-1:0] held_height;

  peak_report_t peak_reports_due[$];

  int errors         = 0;
  int samples_sent   = 0;
  int series_done    = 0;
  int reports_seen   = 0;
  int peaks_seen     = 0;
  int reg_writes     = 0;
  int input_stalls   = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  bit gap_enable     = 1'b1;
  int hold_asked     = 0;
  int hold_given     = 0;
  int rx_hold_left   = 0;
  int unsigned rx_tick = 0;
  rx_mode_t rx_mode  = RX_OPEN;

  peak_picker_min_distance uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .final_sample (final_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .peak_position(peak_position),
    .peak_valid   (peak_valid),
    .end_of_list  (end_of_list),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_history();
    hist_prev   = '0;
    hist_last   = '0;
    seen_count  = 0;
    held_valid  = 1'b0;
    held_index  = 0;
    held_height = '0;
  endfunction

  function automatic void add_report(input logic [ppmd_pkg::POS_W-1:0] position,
                                     input logic found, input logic closing);
    peak_report_t r;
    r.position = position;
    r.found    = found;
    r.closing  = closing;
    peak_reports_due.insert(peak_reports_due.size(), r);
  endfunction

  function automatic void note_peak(input int unsigned idx,
                                    input logic signed [ppmd_pkg::SAMPLE_W-1:0] height);
    if (!held_valid) begin
      held_valid  = 1'b1;
      held_index  = idx;
      held_height = height;
    end else if (idx - held_index > spacing) begin
      add_report(ppmd_pkg::POS_W'(held_index + 1), 1'b1, 1'b0);
      held_index  = idx;
      held_height = height;
    end else if (height > held_height) begin
      held_index  = idx;
      held_height = height;
    end
  endfunction

  function automatic void track_sample(input logic signed [ppmd_pkg::SAMPLE_W-1:0] value,
                                       input logic last);
    int unsigned k;
    k = seen_count;
    if (k < ppmd_pkg::MAX_SAMPLES) begin
      if (k >= 2 && hist_last > threshold && hist_last > hist_prev && hist_last > value)
        note_peak(k - 1, hist_last);
      if (last && k >= 1 && value > threshold && value > hist_last)
        note_peak(k, value);
      hist_prev  = hist_last;
      hist_last  = value;
      seen_count = k + 1;
    end
    if (last) begin
      if (held_valid)
        add_report(ppmd_pkg::POS_W'(held_index + 1), 1'b1, 1'b1);
      else
        add_report('0, 1'b0, 1'b1);
      clear_history();
    end
  endfunction

  task automatic send_sample(input logic signed [ppmd_pkg::SAMPLE_W-1:0] value,
                             input logic last);
    in_valid     <= 1'b1;
    sample       <= value;
    final_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_sample(value, last);
    samples_sent++;
    if (last) series_done++;
    if (gap_enable) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input ppmd_pkg::reg_index_t which,
                           input logic [ppmd_pkg::SAMPLE_W-1:0] value);
    in_valid <= 1'b0;
    while (peak_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (which == ppmd_pkg::REG_MIN_VALUE) threshold = value;
    else spacing = value[ppmd_pkg::POS_W-1:0];
    reg_writes++;
  endtask

  function automatic logic [ppmd_pkg::SAMPLE_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3, 4:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ppmd_pkg::SAMPLE_W-1:0] pick_spacing();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ppmd_pkg::MAX_SAMPLES;
      2, 3:    return $urandom_range(1, 6);
      4:       return $urandom_range(0, 30);
      default: return $urandom_range(0, ppmd_pkg::MAX_SAMPLES);
    endcase
  endfunction

  task automatic run_series(input int len, input series_style_t style, input bit retune);
    logic signed [ppmd_pkg::SAMPLE_W-1:0] value;
    int level;
    level = $urandom_range(0, 200) - 100;
    for (int i = 0; i < len; i++) begin
      if (retune && i == len / 2 && i > 0) begin
        if ($urandom_range(0, 1)) write_reg(ppmd_pkg::REG_MIN_VALUE, pick_threshold());
        else write_reg(ppmd_pkg::REG_MIN_DISTANCE, pick_spacing());
      end
      case (style)
        STYLE_WIDE:   value = $urandom;
        STYLE_NARROW: value = $urandom_range(0, 8) - 4;
        STYLE_SAW: begin
          if (i % 2) value = level + $urandom_range(1, 50);
          else value = level - $urandom_range(0, 50);
        end
        default: begin
          level = level + $urandom_range(0, 20) - 10;
          value = level;
        end
      endcase
      send_sample(value, i == len - 1);
    end
  endtask

  // Edge cases with the registers at their reset values, then the extremes of
  // the sample range and a flat series.
  task automatic test_directed();
    gap_enable = 1'b0;
    send_sample(5, 1'b1);
    send_sample(1, 1'b0);
    send_sample(7, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(3, 1'b0);
    send_sample(3, 1'b0);
    send_sample(3, 1'b1);
  endtask

  // Close peaks compete, distant peaks are confirmed, and register changes in
  // the middle of a series apply to the next decision.
  task automatic test_spacing();
    write_reg(ppmd_pkg::REG_MIN_VALUE, -10);
    write_reg(ppmd_pkg::REG_MIN_DISTANCE, 2);
    gap_enable = 1'b1;
    send_sample(0, 1'b0);
    send_sample(5, 1'b0);
    send_sample(0, 1'b0);
    send_sample(9, 1'b0);
    send_sample(0, 1'b0);
    send_sample(4, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(8, 1'b0);
    send_sample(0, 1'b0);
    write_reg(ppmd_pkg::REG_MIN_DISTANCE, ppmd_pkg::MAX_SAMPLES);
    write_reg(ppmd_pkg::REG_MIN_VALUE, 32'h7FFF_FFFF);
    send_sample(20, 1'b0);
    send_sample(0, 1'b0);
    write_reg(ppmd_pkg::REG_MIN_VALUE, 32'h8000_0000);
    send_sample(30, 1'b0);
    send_sample(0, 1'b0);
    send_sample(40, 1'b1);
  endtask

  task automatic test_random();
    int start;
    int count;
    start = samples_sent;
    count = 0;
    while (samples_sent - start < 1300) begin
      if (count % 8 == 0) begin
        write_reg(ppmd_pkg::REG_MIN_VALUE, pick_threshold());
        write_reg(ppmd_pkg::REG_MIN_DISTANCE, pick_spacing());
      end
      gap_enable = ($urandom_range(0, 3) != 0);
      run_series(($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 20),
                 series_style_t'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
      count++;
    end
  endtask

  // A peak every other sample while the receiver holds off, so the event
  // queue fills and the input stalls.
  task automatic test_backpressure();
    write_reg(ppmd_pkg::REG_MIN_VALUE, 32'h8000_0000);
    write_reg(ppmd_pkg::REG_MIN_DISTANCE, 0);
    gap_enable = 1'b0;
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < 140; i++)
      send_sample((i % 2) ? 1000 + i : 0, i == 139);
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given   <= hold_given + 1;
      rx_hold_left <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      if (rx_tick[5:0] == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick[2:0] < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    peak_report_t due;
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (peak_valid) peaks_seen++;
      if (peak_reports_due.size() == 0) begin
        $error("unexpected result transfer: peak_position %0d peak_valid %0b end_of_list %0b",
               peak_position, peak_valid, end_of_list);
        errors++;
      end else begin
        due = peak_reports_due.pop_front();
        if (peak_position !== due.position) begin
          $error("peak_position: expected %0d, got %0d", due.position, peak_position);
          errors++;
        end
        if (peak_valid !== due.found) begin
          $error("peak_valid: expected %0b, got %0b", due.found, peak_valid);
          errors++;
        end
        if (end_of_list !== due.closing) begin
          $error("end_of_list: expected %0b, got %0b", due.closing, end_of_list);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) input_stalls++;
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, peak_reports_due.size());
        $display("peak_picker_min_distance: mismatch");
        $finish;
      end
    end
  end

  initial begin
    threshold = '0;
    spacing   = '0;
    clear_history();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_spacing();
    test_random();
    test_backpressure();
    in_valid <= 1'b0;
    while (peak_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d samples in %0d series with %0d register writes.",
             samples_sent, series_done, reg_writes);
    $display("Checked %0d reports (%0d carrying a peak); input stalled %0d cycles.",
             reports_seen, peaks_seen, input_stalls);
    if (errors == 0) begin
      $display("peak_picker_min_distance: match");
    end else begin
      $display("peak_picker_min_distance: mismatch");
    end
    $finish;
  end

endmodule
